// File: rtl/bpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpsd_pkg;

  localparam logic REG_RELEASE    = 1'b0;
  localparam logic REG_SUCCESSIVE = 1'b1;

  typedef struct packed {
    logic [31:0] frame_time;
    logic [15:0] pressed_mask;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  key_index;
    logic        key_pressed;
    logic [31:0] pressed_duration;
    logic [3:0]  hit_streak;
    logic        last_key;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic begin_key;
    logic open;
    logic extend;
    logic res_zero;
    logic step;
    logic finish;
    logic finish_inc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic pressed;
    logic was;
    logic fill_zero;
    logic announce;
    logic slot_ok;
    logic first;
    logic last_slot;
    logic last_key;
    logic out_busy;
  } status_t;

  // Signed difference a - b is at most lim, lim non-negative.
  function automatic logic diff_at_most(input logic [31:0] a, input logic [31:0] b,
                                        input logic [15:0] lim);
    logic [31:0] d;
    d = a - b;
    return d[31] || (d <= {16'b0, lim});
  endfunction

endpackage

`default_nettype wire

// File: rtl/bpsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bpsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/bpsd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bpsd_ctrl
  import bpsd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {S_IDLE, S_KEY, S_HELD, S_ITER, S_EMIT} state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_KEY;
        end
      end
      S_KEY: begin
        cmd.begin_key = 1'b1;
        if (status.pressed) begin
          if (!status.was || status.fill_zero) begin
            cmd.open   = 1'b1;
            state_next = S_EMIT;
          end else begin
            state_next = S_HELD;
          end
        end else if (status.fill_zero) begin
          cmd.res_zero = 1'b1;
          state_next   = S_EMIT;
        end else begin
          state_next = S_ITER;
        end
      end
      S_HELD: begin
        cmd.extend = 1'b1;
        state_next = S_EMIT;
      end
      S_ITER: begin
        if (status.first && !status.announce) begin
          cmd.res_zero = 1'b1;
          state_next   = S_EMIT;
        end else if (!status.slot_ok) begin
          cmd.finish = 1'b1;
          state_next = S_EMIT;
        end else if (status.last_slot) begin
          cmd.finish_inc = 1'b1;
          state_next     = S_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = status.last_key ? S_IDLE : S_KEY;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bpsd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bpsd_datapath
  import bpsd_pkg::*;
#(
  parameter int NUM_KEYS       = 16,
  parameter int INTERVAL_SLOTS = 8,
  parameter int HISTORY_FRAMES = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire in_item_t  in_item,
  input  wire cmd_t      cmd,
  output status_t        status,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam int NOUT  = (NUM_KEYS < 16) ? NUM_KEYS : 16;
  localparam int KW    = (NOUT > 1) ? $clog2(NOUT) : 1;
  localparam int SW    = $clog2(INTERVAL_SLOTS);
  localparam int FW    = $clog2(INTERVAL_SLOTS + 1);
  localparam int DEPTH = NOUT * INTERVAL_SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = $clog2(HISTORY_FRAMES + 1);

  logic [15:0]      rel_to;
  logic [15:0]      suc_to;
  logic [31:0]      now_t;
  logic [NOUT-1:0]  cur_mask;
  logic [NOUT-1:0]  prv_mask;
  logic [KW-1:0]    key;
  logic [SW-1:0]    age;
  logic [FW-1:0]    cnt;
  logic [31:0]      prev_start;
  logic [HW-1:0]    hist_fill;
  logic [31:0]      res_dur;
  logic [3:0]       res_streak;
  logic [FW-1:0]    fill [NOUT];
  logic [SW-1:0]    head [NOUT];

  logic [FW-1:0]    cur_fill;
  logic [SW-1:0]    cur_head;
  logic [SW-1:0]    new_head;
  logic [SW-1:0]    rd_age;
  logic [SW-1:0]    slot;
  logic [SW:0]      slot_wrap;
  logic [AW-1:0]    key_base;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [31:0]      wstart;
  logic [31:0]      wend;
  logic [31:0]      rs;
  logic [31:0]      re;
  logic [31:0]      ns;
  logic [31:0]      ne;
  logic [31:0]      oldest;
  logic [FW-1:0]    fin;
  logic [7:0]       fin8;
  logic [3:0]       streak;

  generate
    if (HISTORY_FRAMES == 1) begin : g_hist_one
      assign oldest = now_t;
    end else begin : g_hist_line
      logic [31:0] hist [HISTORY_FRAMES-1];
      always_ff @(posedge clk) begin
        if (cmd.load) begin
          hist[0] <= now_t;
          for (int i = 1; i < HISTORY_FRAMES - 1; i++) begin
            hist[i] <= hist[i-1];
          end
        end
      end
      assign oldest = hist[HISTORY_FRAMES-2];
    end
  endgenerate

  always_comb begin
    cur_fill  = fill[key];
    cur_head  = head[key];
    new_head  = (cur_head == SW'(INTERVAL_SLOTS - 1)) ? '0 : cur_head + SW'(1);
    rd_age    = cmd.step ? age + SW'(1) : '0;
    slot_wrap = {1'b0, cur_head} + (SW+1)'(INTERVAL_SLOTS) - {1'b0, rd_age};
    slot      = (cur_head >= rd_age) ? cur_head - rd_age : slot_wrap[SW-1:0];
    key_base  = AW'(key) * AW'(INTERVAL_SLOTS);
    raddr     = key_base + AW'(slot);
    waddr     = key_base + (cmd.open ? AW'(new_head) : AW'(cur_head));
    ns        = (now_t < rs) ? now_t : rs;
    ne        = (now_t > re) ? now_t : re;
    we        = cmd.open || cmd.extend;
    wstart    = cmd.open ? now_t : ns;
    wend      = cmd.open ? now_t : ne;
    fin       = cmd.finish_inc ? cnt + FW'(1) : cnt;
    fin8      = 8'(fin);
    streak    = (fin8 > 8'd15) ? 4'd15 : fin8[3:0];
  end

  always_comb begin
    status.pressed   = cur_mask[key];
    status.was       = prv_mask[key];
    status.fill_zero = (cur_fill == '0);
    status.announce  = !diff_at_most(now_t, re, suc_to) &&
                       ((hist_fill != HW'(HISTORY_FRAMES)) || diff_at_most(oldest, re, suc_to));
    status.slot_ok   = ((re - rs) < {16'b0, rel_to}) &&
                       ((age == '0) || ((prev_start - re) <= {16'b0, suc_to}));
    status.first     = (age == '0);
    status.last_slot = ((FW'(age) + FW'(1)) == cur_fill);
    status.last_key  = (key == KW'(NOUT - 1));
    status.out_busy  = out_valid && out_stall;
  end

  bpsd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_start_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wstart),
    .raddr (raddr),
    .rdata (rs)
  );

  bpsd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_end_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wend),
    .raddr (raddr),
    .rdata (re)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rel_to    <= 16'd1000;
      suc_to    <= 16'd500;
      cur_mask  <= '0;
      prv_mask  <= '0;
      hist_fill <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NOUT; i++) begin
        fill[i] <= '0;
        head[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_RELEASE) begin
          rel_to <= cfg_data;
        end else if (cfg_index == REG_SUCCESSIVE) begin
          suc_to <= cfg_data;
        end
      end
      if (cmd.load) begin
        prv_mask <= cur_mask;
        cur_mask <= in_item.pressed_mask[NOUT-1:0];
        if (hist_fill != HW'(HISTORY_FRAMES)) begin
          hist_fill <= hist_fill + HW'(1);
        end
      end
      if (cmd.open) begin
        head[key] <= new_head;
        if (cur_fill != FW'(INTERVAL_SLOTS)) begin
          fill[key] <= cur_fill + FW'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_t <= in_item.frame_time;
      key   <= '0;
    end
    if (cmd.begin_key) begin
      age <= '0;
      cnt <= '0;
    end
    if (cmd.step) begin
      age        <= age + SW'(1);
      cnt        <= cnt + FW'(1);
      prev_start <= rs;
    end
    if (cmd.open || cmd.res_zero) begin
      res_dur    <= '0;
      res_streak <= '0;
    end
    if (cmd.extend) begin
      res_dur    <= ne - ns;
      res_streak <= '0;
    end
    if (cmd.finish || cmd.finish_inc) begin
      res_dur    <= '0;
      res_streak <= streak;
    end
    if (cmd.emit) begin
      out_item.key_index        <= 4'(key);
      out_item.key_pressed      <= cur_mask[key];
      out_item.pressed_duration <= res_dur;
      out_item.hit_streak       <= res_streak;
      out_item.last_key         <= status.last_key;
      key                       <= key + KW'(1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/button_press_streak_detector.sv
// Each frame transfer yields one result per key, in ascending key order.
// A key goes from S_KEY straight to S_EMIT when it opens an interval or has none, through S_HELD
// when held, and through S_ITER when released, one interval ring read per cycle.
// The next frame is taken once the last result is in the output register.
// Synchronous reset clears masks, ring counts and heads; timeouts return to 1000 and 500.
`timescale 1ns / 1ps
`default_nettype none

module button_press_streak_detector
  import bpsd_pkg::*;
#(
  parameter int NUM_KEYS       = 16,
  parameter int INTERVAL_SLOTS = 8,
  parameter int HISTORY_FRAMES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item
);

  cmd_t    cmd;
  status_t status;

  bpsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bpsd_datapath #(
    .NUM_KEYS       (NUM_KEYS),
    .INTERVAL_SLOTS (INTERVAL_SLOTS),
    .HISTORY_FRAMES (HISTORY_FRAMES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
